### hdl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
  // floor(n / 10) == (n * RECIP_TEN) >> RECIP_SHIFT for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIGIT,
    ST_EMIT
  } state_e;

  // Request to the divide-by-ten unit
  typedef struct packed {
    logic step;  // advance one digit
    logic load;  // take a fresh operand instead of the held quotient
  } div_ctrl_t;

  // Result of the last step
  typedef struct packed {
    logic [QUOT_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

### hdl/sitda_div10.sv
// Divide-by-ten unit: one quotient and remainder digit per step.
module sitda_div10 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sitda_pkg::div_ctrl_t          ctrl_i,
  input  logic [sitda_pkg::VALUE_W-1:0] operand_i,
  output sitda_pkg::div_res_t           res_o
);
  import sitda_pkg::*;

  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [DIGIT_W-1:0]   lo_q, lo_d;
  logic [VALUE_W-1:0]   src;
  logic [2*VALUE_W-1:0] prod;
  logic [2*DIGIT_W-1:0] q_times_ten;

  assign src    = ctrl_i.load ? operand_i : VALUE_W'(quot_q);
  assign prod   = (2*VALUE_W)'(src) * (2*VALUE_W)'(RECIP_TEN);
  assign quot_d = prod[2*VALUE_W-1:RECIP_SHIFT];
  assign lo_d   = src[DIGIT_W-1:0];

  // remainder < 10, so the low nibble of n - 10q is enough
  assign q_times_ten = (2*DIGIT_W)'(quot_q[DIGIT_W-1:0]) * (2*DIGIT_W)'(RADIX);
  assign res_o.quot  = quot_q;
  assign res_o.rem   = lo_q - q_times_ten[DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      lo_q   <= '0;
    end else if (ctrl_i.step) begin
      quot_q <= quot_d;
      lo_q   <= lo_d;
    end
  end

endmodule

### hdl/signed_int_to_decimal_ascii_top.sv
// Top level: signed 32-bit integer in, decimal ASCII characters out.
//
// Converts one two's complement 32-bit value per request into its decimal
// text, most significant character first, with last_o set on the final
// character. Negative values lead with '-', zero gives "0", and the most
// negative value gives "-2147483648". Per request the value is taken and
// its magnitude formed, the divider is started, the divide-by-ten loop
// yields the decimal digits (1 to 10 of them), and then each character
// (the digits, plus one for a sign) goes through the output register,
// one character a cycle while the receiver does not stall. The pace is
// set by the single shared divide-by-ten unit (a reciprocal multiply, one
// digit a cycle) and the one-character output register. The input is
// stalled from acceptance until the last character has been loaded into
// the output register; that character may still be waiting downstream
// while the next request is taken.
module signed_int_to_decimal_ascii_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sitda_pkg::VALUE_W-1:0] value_i,
  // character channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [sitda_pkg::CHAR_W-1:0]  character_o,
  output logic                                 last_o
);
  import sitda_pkg::*;

  state_e state_q, state_d;

  // captured request
  logic [VALUE_W-1:0] mag_q;
  logic [VALUE_W-1:0] raw;

  // digit store, least significant digit at index 0
  logic [DIGIT_W-1:0] digits_q [MAX_DIGITS];
  logic [CNT_W-1:0]   ndig_q;    // digits written so far
  logic [CNT_W-1:0]   pos_q;     // digits still to send
  logic               minus_pend_q;
  logic [DIG_IDX_W-1:0] rd_idx;

  // output register
  logic              out_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;

  // sequencer outputs
  logic      capture;
  logic      dig_we;
  logic      dig_last;
  logic      out_free;
  logic      out_load;
  div_ctrl_t div_ctrl;
  div_res_t  div_res;

  sitda_div10 u_div10 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .operand_i (mag_q),
    .res_o     (div_res)
  );

  assign raw      = $unsigned(value_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_idx   = DIG_IDX_W'(pos_q - CNT_W'(1));

  // sequencer: next state and per-state strobes
  always_comb begin
    state_d  = state_q;
    capture  = 1'b0;
    dig_we   = 1'b0;
    dig_last = 1'b0;
    out_load = 1'b0;
    div_ctrl = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          capture = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_ctrl.step = 1'b1;
        div_ctrl.load = 1'b1;
        state_d       = ST_DIGIT;
      end
      ST_DIGIT: begin
        // a digit falls out of the divider every cycle here
        dig_we = 1'b1;
        if (div_res.quot == '0 || ndig_q == CNT_W'(MAX_DIGITS - 1)) begin
          dig_last = 1'b1;
          state_d  = ST_EMIT;
        end else begin
          div_ctrl.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!minus_pend_q && pos_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture: magnitude in unsigned arithmetic covers -2^31 too
  always_ff @(posedge clk_i) begin
    if (capture) begin
      mag_q <= raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[ndig_q[DIG_IDX_W-1:0]] <= div_res.rem;
    end
  end

  // digit counters and sign flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q       <= '0;
      pos_q        <= '0;
      minus_pend_q <= 1'b0;
    end else begin
      if (capture) begin
        minus_pend_q <= raw[VALUE_W-1];
      end
      if (div_ctrl.load) begin
        ndig_q <= '0;
      end else if (dig_we) begin
        ndig_q <= ndig_q + CNT_W'(1);
      end
      if (dig_last) begin
        pos_q <= ndig_q + CNT_W'(1);
      end else if (out_load) begin
        if (minus_pend_q) begin
          minus_pend_q <= 1'b0;
        end else begin
          pos_q <= pos_q - CNT_W'(1);
        end
      end
    end
  end

  // output register: refilled as soon as the held character is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (minus_pend_q) begin
        char_q <= CHAR_MINUS;
        last_q <= 1'b0;
      end else begin
        char_q <= CHAR_ZERO + CHAR_W'(digits_q[rd_idx]);
        last_q <= (pos_q == CNT_W'(1));
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

### bench/tb_top.sv
// Self-checking bench for the signed integer to decimal ASCII converter.
`timescale 1ns / 100ps

module tb_top;
  import sitda_pkg::*;

  // Run shape: random requests, when the receiver's long hold begins and how long it lasts
  localparam int unsigned RANDOM_REQS  = 400;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;   // longer than the slowest unstalled request
  localparam int unsigned MAX_REPORTS  = 40;

  // One entry of the pending list: a value to convert, or a marker that makes
  // the sender wait until every character owed so far has come back.
  typedef struct {
    bit                 pause;
    logic [VALUE_W-1:0] value;
  } request_t;

  // One expected character of the output text
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [VALUE_W-1:0]  value_i     = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic        [CHAR_W-1:0]   character_o;
  logic                       last_o;

  request_t    pending[$];
  text_char_t  chars_due[$];

  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned chars_checked = 0;
  int unsigned texts_closed  = 0;
  int unsigned pauses_done   = 0;
  int unsigned tx_gap        = 0;
  int unsigned tx_calm       = 0;
  int unsigned rx_gap        = 0;
  int unsigned rx_calm       = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  request_t    head;
  text_char_t  due;

  signed_int_to_decimal_ascii_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reset held low from the start, released once and never again
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard limit, several times the slowest legal run
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  // One line per mismatch; printing is capped but every one is counted
  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Idle length: mostly none or short, now and then long, and calm stretches
  // of back-to-back traffic so that some phases see no gaps at all.
  function automatic int unsigned pick_gap(ref int unsigned calm_left);
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 3) begin
      calm_left = $urandom_range(40, 15);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(30, 11);
  endfunction

  // Decimal text of a two's complement value: magnitude formed unsigned (so the
  // most negative value needs no special path), digits pulled out least
  // significant first, then queued most significant first behind any sign.
  task automatic predict_text(input logic [VALUE_W-1:0] raw);
    logic               negative;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    int unsigned        ndig;
    text_char_t         c;
    negative = raw[VALUE_W-1];
    mag      = negative ? (32'd0 - raw) : raw;
    ndig     = 0;
    do begin
      digits[ndig] = DIGIT_W'(mag % RADIX);
      mag          = mag / RADIX;
      ndig++;
    end while (mag != 0 && ndig < MAX_DIGITS);
    if (negative) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      chars_due.push_back(c);
    end
    for (int k = ndig; k > 0; k--) begin
      c.ch   = CHAR_ZERO + CHAR_W'(digits[k-1]);
      c.last = (k == 1);
      chars_due.push_back(c);
    end
  endtask

  // Random value with a chosen number of digits and a random sign, so that
  // every text length turns up often rather than mostly ten-digit numbers.
  function automatic logic [VALUE_W-1:0] value_of_length();
    int unsigned        d;
    longint unsigned    lo;
    longint unsigned    hi;
    logic [VALUE_W-1:0] v;
    d  = $urandom_range(MAX_DIGITS, 1);
    lo = (d == 1) ? 0 : 1;
    for (int i = 1; i < d; i++) lo = lo * 10;
    hi = (d == MAX_DIGITS) ? 64'd2147483647 : lo * 10 - 1;
    if (d == 1) hi = 9;
    v = $urandom_range(hi, lo);
    if ($urandom_range(1, 0)) v = 32'd0 - v;
    return v;
  endfunction

  function automatic request_t make_req(input logic [VALUE_W-1:0] v);
    request_t r;
    r.pause = 1'b0;
    r.value = v;
    return r;
  endfunction

  // Sender: offers the head of the pending list, holds it while stalled,
  // predicts on acceptance, and inserts random gaps between requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_text(value_i);
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        // pause marker: hold off until all owed characters are back
        if (pending.size() > 0 && pending[0].pause && chars_due.size() == 0) begin
          void'(pending.pop_front());
          pauses_done++;
        end
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0 && !pending[0].pause) begin
          head = pending.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= head.value;
          tx_gap      = pick_gap(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random gaps, plus one long hold once enough requests have
  // gone in, so the output backs up and the input is stalled for a while.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        rx_gap       = pick_gap(rx_calm);
      end
    end
  end

  // Checker: every accepted character against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  character_o, last_o));
      end else begin
        due = chars_due.pop_front();
        chars_checked++;
        if (character_o !== due.ch) begin
          report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    character_o, due.ch));
        end
        if (last_o !== due.last) begin
          report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                    last_o, due.last, due.ch));
        end
        if (due.last) texts_closed++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [VALUE_W-1:0] v;
    request_t           marker;
    int unsigned        kind;
    marker.pause = 1'b1;
    marker.value = '0;

    // directed: zero, single digits, several length edges, both extremes,
    // alternating bit patterns
    pending.push_back(make_req(32'd0));
    pending.push_back(make_req(32'd1));
    pending.push_back(make_req(-32'sd1));
    pending.push_back(make_req(32'd9));
    pending.push_back(make_req(32'd10));
    pending.push_back(make_req(-32'sd10));
    pending.push_back(make_req(-32'sd5));
    pending.push_back(make_req(32'd99));
    pending.push_back(make_req(32'd100));
    pending.push_back(make_req(32'd999999999));
    pending.push_back(make_req(-32'sd999999999));
    pending.push_back(make_req(32'd1000000000));
    pending.push_back(make_req(-32'sd1000000000));
    pending.push_back(make_req(32'd1999999999));
    pending.push_back(make_req(32'd123456789));
    pending.push_back(make_req(32'h7FFF_FFFF));
    pending.push_back(make_req(32'h8000_0000));
    pending.push_back(make_req(32'h8000_0001));
    pending.push_back(make_req(32'h5555_5555));
    pending.push_back(make_req(32'hAAAA_AAAA));
    pending.push_back(marker);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 2) pending.push_back(marker);
      kind = $urandom_range(9, 0);
      if (kind < 4) begin
        v = $urandom();
      end else if (kind < 9) begin
        v = value_of_length();
      end else begin
        // near a power of ten, or one of the extremes
        v = 1;
        repeat ($urandom_range(9, 0)) v = v * 10;
        v = v + $urandom_range(2, 0) - 1;
        if ($urandom_range(1, 0)) v = 32'd0 - v;
        if ($urandom_range(7, 0) == 0) v = $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      pending.push_back(make_req(v));
    end

    @(posedge rst_ni);
    while (pending.size() > 0 || in_valid_i) @(posedge clk_i);
    while (chars_due.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d values into %0d checked characters (%0d complete texts).",
             items_sent, chars_checked, texts_closed);
    $display("Included a %0d-cycle output hold and %0d full drains; %0d mismatches.",
             HOLD_CYCLES, pauses_done, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
